FILE: rtl/core/mfru_pkg.sv
// Shared types and constants for the marker frame receiver and unpacker.
`timescale 1ns / 1ps

package mfru_pkg;

   localparam logic [7:0]  START_BYTE       = 8'hAA;
   localparam logic [7:0]  END_BYTE         = 8'h55;
   localparam int          BODY_LEN         = 13;
   localparam int          COUNT_W          = $clog2(BODY_LEN + 1);
   localparam int          TICK_W           = 24;
   localparam logic [23:0] TICK_MAX         = 24'hFFFFFF;
   localparam logic [23:0] TIMEOUT_RESET    = 24'd1000;
   localparam int          CSR_DATA_W       = 24;
   localparam int          CSR_INDEX_W      = 2;
   localparam int          QUEUE_DEPTH_DEF  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_X  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS_Y  = 2'd2;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      STATUS_VALID   = 2'd0,
      STATUS_BAD_END = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   // one finished frame or error event, frame byte 1 at index 0
   typedef struct packed {
      status_type                   status;
      logic [BODY_LEN-1:0][7:0]     body;
   } event_type;

endpackage

FILE: rtl/core/mfru_front.sv
// Front end: hunts for the start byte, collects the frame body and tracks ticks.
`timescale 1ns / 1ps

module mfru_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       op,
   input  logic [7:0]                 rx_byte,
   input  logic [mfru_pkg::TICK_W-1:0] timeout_ticks,
   output logic                       event_push,
   output mfru_pkg::event_type        event_data
);
   import mfru_pkg::*;

   logic                          collecting_ff, collecting_in;
   logic [COUNT_W-1:0]            count_ff, count_in;
   logic [TICK_W-1:0]             ticks_ff, ticks_in;
   logic [BODY_LEN-1:0][7:0]      body_ff, body_in;
   logic [TICK_W-1:0]             ticks_inc;

   assign ticks_inc = (ticks_ff == TICK_MAX) ? TICK_MAX : ticks_ff + TICK_W'(1);

   always_comb begin
      collecting_in     = collecting_ff;
      count_in          = count_ff;
      ticks_in          = ticks_ff;
      body_in           = body_ff;
      event_push        = 1'b0;
      event_data.status = STATUS_VALID;
      event_data.body   = body_ff;
      if (accept) begin
         if (op == OP_TICK) begin
            ticks_in = ticks_inc;
            if (ticks_inc > timeout_ticks) begin
               event_push        = 1'b1;
               event_data.status = STATUS_TIMEOUT;
               collecting_in     = 1'b0;
               count_in          = '0;
               ticks_in          = '0;
            end
         end else if (!collecting_ff) begin
            if (rx_byte == START_BYTE) begin
               collecting_in = 1'b1;
               count_in      = '0;
               ticks_in      = '0;
            end
         end else if (count_ff < COUNT_W'(BODY_LEN)) begin
            // oldest byte shifts toward index 0
            body_in  = {rx_byte, body_ff[BODY_LEN-1:1]};
            count_in = count_ff + COUNT_W'(1);
         end else begin
            event_push        = 1'b1;
            event_data.status = (rx_byte == END_BYTE) ? STATUS_VALID : STATUS_BAD_END;
            collecting_in     = 1'b0;
            count_in          = '0;
            ticks_in          = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff <= 1'b0;
         count_ff      <= '0;
         ticks_ff      <= '0;
      end else begin
         collecting_ff <= collecting_in;
         count_ff      <= count_in;
         ticks_ff      <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
   end

endmodule

FILE: rtl/core/mfru_queue.sv
// Short queue of frame events between the front end and the unpacker.
`timescale 1ns / 1ps

module mfru_queue #(
   parameter int QUEUE_DEPTH = mfru_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mfru_pkg::event_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output mfru_pkg::event_type  pop_data
);
   import mfru_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   event_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/mfru_back.sv
// Back end: unpacks frame events into result words and holds the output register.
`timescale 1ns / 1ps

module mfru_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  mfru_pkg::event_type  queue_data,
   output logic                 queue_pop,
   input  logic signed [15:0]   bias_x,
   input  logic signed [15:0]   bias_y,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_voltage_word,
   output logic [15:0]          rsp_current_word,
   output logic [15:0]          rsp_pressure_word,
   output logic [15:0]          rsp_speed_word,
   output logic signed [15:0]   rsp_accel_x_value,
   output logic signed [15:0]   rsp_accel_y_value,
   output logic [7:0]           rsp_relay_status
);
   import mfru_pkg::*;

   logic                 valid_ff, valid_in;
   logic [1:0]           status_ff, status_in;
   logic [15:0]          voltage_ff, voltage_in;
   logic [15:0]          current_ff, current_in;
   logic [15:0]          pressure_ff, pressure_in;
   logic [15:0]          speed_ff, speed_in;
   logic [15:0]          accel_x_ff, accel_x_in;
   logic [15:0]          accel_y_ff, accel_y_in;
   logic [7:0]           relay_ff, relay_in;
   logic                 load;
   logic                 good;

   assign load      = !queue_empty && (!valid_ff || rsp_pop);
   assign queue_pop = load;
   assign good      = (queue_data.status == STATUS_VALID);

   always_comb begin
      valid_in    = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
      status_in   = queue_data.status;
      voltage_in  = good ? {queue_data.body[0],  queue_data.body[1]}  : '0;
      current_in  = good ? {queue_data.body[2],  queue_data.body[3]}  : '0;
      pressure_in = good ? {queue_data.body[4],  queue_data.body[5]}  : '0;
      speed_in    = good ? {queue_data.body[6],  queue_data.body[7]}  : '0;
      accel_x_in  = good ? {queue_data.body[8],  queue_data.body[9]}  - bias_x : '0;
      accel_y_in  = good ? {queue_data.body[10], queue_data.body[11]} - bias_y : '0;
      relay_in    = good ? queue_data.body[12] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff   <= status_in;
         voltage_ff  <= voltage_in;
         current_ff  <= current_in;
         pressure_ff <= pressure_in;
         speed_ff    <= speed_in;
         accel_x_ff  <= accel_x_in;
         accel_y_ff  <= accel_y_in;
         relay_ff    <= relay_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_voltage_word  = voltage_ff;
   assign rsp_current_word  = current_ff;
   assign rsp_pressure_word = pressure_ff;
   assign rsp_speed_word    = speed_ff;
   assign rsp_accel_x_value = accel_x_ff;
   assign rsp_accel_y_value = accel_y_ff;
   assign rsp_relay_status  = relay_ff;

endmodule

FILE: rtl/core/marker_frame_receiver_unpacker_core.sv
// Top level of the marker frame receiver and unpacker.
`timescale 1ns / 1ps

// Takes one request per cycle while req_full is low, either a received byte
// or a time tick, and yields a result for each finished frame (valid or bad
// end marker) or timeout. The front end classifies each request in the cycle
// it is taken; an event is written into a QUEUE_DEPTH-entry queue and then
// loaded into the output register once that register is empty or popped.
// The front end only stalls (req_full) while the event queue is full, which
// happens only when results are not popped. csr registers: 0 timeout in
// ticks, 1 and 2 the X and Y acceleration offsets; write them while idle.

module marker_frame_receiver_unpacker_core #(
   parameter int QUEUE_DEPTH = mfru_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_op,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [1:0]                        rsp_status,
   output logic [15:0]                       rsp_voltage_word,
   output logic [15:0]                       rsp_current_word,
   output logic [15:0]                       rsp_pressure_word,
   output logic [15:0]                       rsp_speed_word,
   output logic signed [15:0]                rsp_accel_x_value,
   output logic signed [15:0]                rsp_accel_y_value,
   output logic [7:0]                        rsp_relay_status,
   input  logic                              csr_write,
   input  logic [mfru_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mfru_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfru_pkg::*;

   logic [TICK_W-1:0]    timeout_ff;
   logic signed [15:0]   bias_x_ff;
   logic signed [15:0]   bias_y_ff;
   logic                 accept;
   logic                 event_push;
   event_type            event_data;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 queue_pop;
   event_type            queue_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         bias_x_ff  <= '0;
         bias_y_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_wdata[TICK_W-1:0];
            CSR_BIAS_X:  bias_x_ff  <= csr_wdata[15:0];
            CSR_BIAS_Y:  bias_y_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   mfru_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_op),
      .rx_byte       (req_rx_byte),
      .timeout_ticks (timeout_ff),
      .event_push    (event_push),
      .event_data    (event_data)
   );

   mfru_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (event_push),
      .push_data (event_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (queue_data)
   );

   mfru_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_data        (queue_data),
      .queue_pop         (queue_pop),
      .bias_x            (bias_x_ff),
      .bias_y            (bias_y_ff),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_status        (rsp_status),
      .rsp_voltage_word  (rsp_voltage_word),
      .rsp_current_word  (rsp_current_word),
      .rsp_pressure_word (rsp_pressure_word),
      .rsp_speed_word    (rsp_speed_word),
      .rsp_accel_x_value (rsp_accel_x_value),
      .rsp_accel_y_value (rsp_accel_y_value),
      .rsp_relay_status  (rsp_relay_status)
   );

endmodule
